// ===== rtl/core/sbc_pkg.sv =====
package sbc_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int BYTE_W          = 8;
   localparam int SENSOR_W        = 12;
   localparam int BUDGET_W        = 12;
   localparam int REQ_DATA_W      = 24;
   localparam logic [BUDGET_W-1:0] BUDGET_RESET = 12'd1024;

   localparam logic [BYTE_W-1:0] OP_NOP   = 8'h00;
   localparam logic [BYTE_W-1:0] OP_PUSH  = 8'h01;
   localparam logic [BYTE_W-1:0] OP_POP   = 8'h02;
   localparam logic [BYTE_W-1:0] OP_DUP   = 8'h03;
   localparam logic [BYTE_W-1:0] OP_SWAP  = 8'h04;
   localparam logic [BYTE_W-1:0] OP_ADD   = 8'h10;
   localparam logic [BYTE_W-1:0] OP_SUB   = 8'h11;
   localparam logic [BYTE_W-1:0] OP_MUL   = 8'h12;
   localparam logic [BYTE_W-1:0] OP_DIV   = 8'h13;
   localparam logic [BYTE_W-1:0] OP_NEG   = 8'h15;
   localparam logic [BYTE_W-1:0] OP_ABS   = 8'h16;
   localparam logic [BYTE_W-1:0] OP_LT    = 8'h22;
   localparam logic [BYTE_W-1:0] OP_GT    = 8'h23;
   localparam logic [BYTE_W-1:0] OP_LE    = 8'h24;
   localparam logic [BYTE_W-1:0] OP_GE    = 8'h25;
   localparam logic [BYTE_W-1:0] OP_RANGE = 8'h40;
   localparam logic [BYTE_W-1:0] OP_HALT  = 8'h54;
   localparam logic [BYTE_W-1:0] OP_NOP_A = 8'h60;
   localparam logic [BYTE_W-1:0] OP_NOP_B = 8'h61;
   localparam logic [BYTE_W-1:0] OP_CID   = 8'h63;

   typedef enum logic [2:0] {
      ST_OK,
      ST_UNDER,
      ST_OVER,
      ST_BADOP,
      ST_DIVZ,
      ST_NOOPND,
      ST_DEADLINE
   } status_type;

   typedef enum logic [1:0] {
      AW_NONE,
      AW_PUSH,
      AW_CID
   } await_type;

   typedef struct packed {
      logic       load;
      logic       start;
      logic       ignore;
      logic       operand;
      logic       exec;
      logic       halt;
      logic       set_await;
      await_type  await_code;
      logic       set_stat;
      status_type stat_code;
      logic       pop_a;
      logic       pop_b;
      logic       pop_c;
      logic       alu;
      logic       div_start;
      logic       div_load;
      logic       push;
      logic       push_a;
      logic       finish;
   } dp_cmd_type;

   typedef struct packed {
      logic              start_item;
      logic              finished;
      await_type         await_code;
      logic              over_budget;
      logic [BYTE_W-1:0] code_byte;
      logic              empty;
      logic              lt2;
      logic              full;
      logic              b_zero;
      logic              div_done;
   } dp_status_type;

endpackage

// ===== rtl/core/sbc_div.sv =====
module sbc_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic signed [7:0] dividend,
   input  logic signed [7:0] divisor,
   output logic              done,
   output logic signed [7:0] quotient
);
   logic       run_ff;
   logic [2:0] cnt_ff;
   logic [7:0] rem_ff;
   logic [7:0] quo_ff;
   logic [7:0] dsr_ff;
   logic       neg_ff;
   logic       done_ff;
   logic [8:0] shifted;
   logic [8:0] diff;
   logic       ge;
   logic [7:0] mag_a;
   logic [7:0] mag_b;

   assign mag_a   = dividend[7] ? 8'(-dividend) : dividend;
   assign mag_b   = divisor[7] ? 8'(-divisor) : divisor;
   assign shifted = {rem_ff, quo_ff[7]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign ge      = shifted >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= mag_a;
         dsr_ff <= mag_b;
         neg_ff <= dividend[7] ^ divisor[7];
      end else if (run_ff) begin
         rem_ff <= ge ? diff[7:0] : shifted[7:0];
         quo_ff <= {quo_ff[6:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? 8'(-quo_ff) : quo_ff;

endmodule

// ===== rtl/core/sbc_dpath.sv =====
module sbc_dpath #(
   parameter  int STACK_DEPTH = sbc_pkg::STACK_DEPTH_DEF,
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1),
   localparam int ADDR_W      = $clog2(STACK_DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [sbc_pkg::BUDGET_W-1:0]  csr_wdata,
   input  logic                          in_command,
   input  logic [sbc_pkg::BYTE_W-1:0]    in_code_byte,
   input  logic                          in_last,
   input  logic [sbc_pkg::SENSOR_W-1:0]  in_sensor,
   input  sbc_pkg::dp_cmd_type           cmd,
   output sbc_pkg::dp_status_type        st,
   output logic                          done_res,
   output sbc_pkg::status_type           status,
   output logic                          ignored,
   output logic [7:0]                    violation_mask,
   output logic [1:0]                    severity,
   output logic [sbc_pkg::BUDGET_W-1:0]  instruction_count,
   output logic signed [7:0]             top_value,
   output logic [DEPTH_W-1:0]            stack_depth
);
   import sbc_pkg::*;

   function automatic logic signed [7:0] sat127(input logic signed [15:0] v);
      logic signed [7:0] r;
      if (v < -16'sd127) r = -8'sd127;
      else if (v > 16'sd127) r = 8'sd127;
      else r = v[7:0];
      return r;
   endfunction

   logic signed [7:0]     mem [STACK_DEPTH];

   logic                  item_cmd_ff;
   logic [BYTE_W-1:0]     byte_ff;
   logic                  last_ff;
   logic [SENSOR_W-1:0]   sensor_ff;
   logic [BUDGET_W-1:0]   budget_ff;
   logic [DEPTH_W-1:0]    depth_ff;
   logic [7:0]            cid_ff;
   logic [7:0]            mask_ff;
   logic [BUDGET_W-1:0]   count_ff;
   await_type             await_ff;
   logic                  fin_ff;
   status_type            stat_ff;
   logic                  done_ff;
   logic                  ign_ff;
   logic [1:0]            sev_ff;
   logic                  live_ff;
   logic                  halt_ff;
   logic signed [7:0]     a_ff;
   logic signed [7:0]     b_ff;
   logic signed [7:0]     c_ff;
   logic signed [7:0]     top_ff;
   logic signed [15:0]    res_ff;

   logic [DEPTH_W-1:0]    depth_dec;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ADDR_W-1:0]     wr_addr;
   logic signed [15:0]    xa;
   logic signed [15:0]    xb;
   logic signed [15:0]    alu_val;
   logic signed [15:0]    push_val;
   logic                  range_hit;
   logic [3:0]            ones;
   logic [1:0]            sev_val;
   logic                  div_done;
   logic signed [7:0]     div_q;

   assign depth_dec = depth_ff - DEPTH_W'(1);
   assign rd_addr   = depth_dec[ADDR_W-1:0];
   assign wr_addr   = depth_ff[ADDR_W-1:0];
   assign xa        = {{8{a_ff[7]}}, a_ff};
   assign xb        = {{8{b_ff[7]}}, b_ff};
   assign range_hit = (a_ff < b_ff) || (a_ff > c_ff);
   assign push_val  = cmd.push_a ? xa : res_ff;
   assign ones      = 4'($countones(mask_ff));

   always_comb begin
      if (ones == 4'd0) sev_val = 2'd0;
      else if (ones <= 4'd2) sev_val = 2'd1;
      else if (ones <= 4'd4) sev_val = 2'd2;
      else sev_val = 2'd3;
   end

   always_comb begin
      case (byte_ff)
         OP_ADD:   alu_val = xa + xb;
         OP_SUB:   alu_val = xa - xb;
         OP_MUL:   alu_val = xa * xb;
         OP_LT:    alu_val = {15'd0, a_ff < b_ff};
         OP_GT:    alu_val = {15'd0, a_ff > b_ff};
         OP_LE:    alu_val = {15'd0, a_ff <= b_ff};
         OP_GE:    alu_val = {15'd0, a_ff >= b_ff};
         OP_NEG:   alu_val = -xa;
         OP_ABS:   alu_val = a_ff[7] ? -xa : xa;
         OP_SWAP:  alu_val = xb;
         OP_RANGE: alu_val = {15'd0, range_hit};
         default:  alu_val = xa;
      endcase
   end

   sbc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (a_ff),
      .divisor  (b_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // stack memory, one write and one read address
   always_ff @(posedge clock) begin
      if (cmd.push) mem[wr_addr] <= sat127(push_val);
   end

   always_ff @(posedge clock) begin
      if (cmd.pop_a) a_ff <= mem[rd_addr];
      if (cmd.pop_b) b_ff <= mem[rd_addr];
      if (cmd.pop_c) c_ff <= mem[rd_addr];
      if (cmd.finish && depth_ff != '0) top_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_cmd_ff <= in_command;
         byte_ff     <= in_code_byte;
         last_ff     <= in_last;
         sensor_ff   <= in_sensor;
      end
      if (cmd.start) begin
         res_ff <= (sensor_ff > SENSOR_W'(127)) ? 16'sd127 : {4'd0, sensor_ff};
      end else if (cmd.operand) begin
         res_ff <= {{8{byte_ff[7]}}, byte_ff};
      end else if (cmd.alu) begin
         res_ff <= alu_val;
      end else if (cmd.div_load) begin
         res_ff <= {{8{div_q[7]}}, div_q};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_RESET;
         depth_ff  <= '0;
         cid_ff    <= '0;
         mask_ff   <= '0;
         count_ff  <= '0;
         await_ff  <= AW_NONE;
         fin_ff    <= 1'b1;
         stat_ff   <= ST_OK;
         done_ff   <= 1'b0;
         ign_ff    <= 1'b0;
         sev_ff    <= '0;
         live_ff   <= 1'b0;
         halt_ff   <= 1'b0;
      end else begin
         if (csr_we) budget_ff <= csr_wdata;
         if (cmd.load) begin
            stat_ff <= ST_OK;
            done_ff <= 1'b0;
            ign_ff  <= 1'b0;
            sev_ff  <= '0;
            live_ff <= 1'b0;
            halt_ff <= 1'b0;
         end
         if (cmd.start) begin
            depth_ff <= '0;
            cid_ff   <= '0;
            mask_ff  <= '0;
            count_ff <= '0;
            await_ff <= AW_NONE;
            fin_ff   <= 1'b0;
         end
         if (cmd.ignore) ign_ff <= 1'b1;
         if (cmd.operand) begin
            live_ff  <= 1'b1;
            await_ff <= AW_NONE;
            if (await_ff == AW_CID) cid_ff <= byte_ff;
         end
         if (cmd.exec) begin
            live_ff  <= 1'b1;
            count_ff <= count_ff + BUDGET_W'(1);
         end
         if (cmd.halt) halt_ff <= 1'b1;
         if (cmd.set_await) await_ff <= cmd.await_code;
         if (cmd.set_stat) stat_ff <= cmd.stat_code;
         if (cmd.pop_a || cmd.pop_b || cmd.pop_c) depth_ff <= depth_dec;
         if (cmd.push) depth_ff <= depth_ff + DEPTH_W'(1);
         if (cmd.alu && byte_ff == OP_RANGE && range_hit && cid_ff < 8'd8) begin
            mask_ff[cid_ff[2:0]] <= 1'b1;
         end
         if (cmd.finish) begin
            if (stat_ff != ST_OK) begin
               done_ff  <= 1'b1;
               fin_ff   <= 1'b1;
               await_ff <= AW_NONE;
            end else if (live_ff && (halt_ff || last_ff)) begin
               done_ff <= 1'b1;
               fin_ff  <= 1'b1;
               if (await_ff != AW_NONE) begin
                  stat_ff  <= ST_NOOPND;
                  await_ff <= AW_NONE;
               end else begin
                  sev_ff <= sev_val;
               end
            end
         end
      end
   end

   always_comb begin
      st.start_item  = !item_cmd_ff;
      st.finished    = fin_ff;
      st.await_code  = await_ff;
      st.over_budget = count_ff >= budget_ff;
      st.code_byte   = byte_ff;
      st.empty       = depth_ff == '0;
      st.lt2         = depth_ff < DEPTH_W'(2);
      st.full        = depth_ff >= DEPTH_W'(STACK_DEPTH);
      st.b_zero      = b_ff == '0;
      st.div_done    = div_done;
   end

   assign done_res          = done_ff;
   assign status            = stat_ff;
   assign ignored           = ign_ff;
   assign violation_mask    = mask_ff;
   assign severity          = sev_ff;
   assign instruction_count = count_ff;
   assign top_value         = (depth_ff != '0) ? top_ff : '0;
   assign stack_depth       = depth_ff;

endmodule

// ===== rtl/core/sbc_ctrl.sv =====
module sbc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   out_free,
   input  sbc_pkg::dp_status_type st,
   output sbc_pkg::dp_cmd_type    cmd,
   output logic                   req_tready,
   output logic                   rsp_load
);
   import sbc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_POPC,
      S_POPB,
      S_POPA,
      S_ALU,
      S_DIVCHK,
      S_DIVW,
      S_PUSH1,
      S_PUSH2,
      S_FINISH,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      PT_DROP,
      PT_ALU,
      PT_DIV
   } path_type;

   state_type state_ff, state_in;
   path_type  path_ff, path_in;
   logic      two_ff, two_in;
   logic      ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         path_ff  <= PT_DROP;
         two_ff   <= 1'b0;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         path_ff  <= path_in;
         two_ff   <= two_in;
         ready_ff <= state_in == S_IDLE;
      end
   end

   always_comb begin
      state_in = state_ff;
      path_in  = path_ff;
      two_in   = two_ff;
      cmd      = '0;
      rsp_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            two_in = 1'b0;
            if (st.start_item) begin
               cmd.start = 1'b1;
               state_in  = S_PUSH1;
            end else if (st.finished) begin
               cmd.ignore = 1'b1;
               state_in   = S_FINISH;
            end else if (st.await_code != AW_NONE) begin
               cmd.operand = 1'b1;
               state_in    = (st.await_code == AW_PUSH) ? S_PUSH1 : S_FINISH;
            end else if (st.over_budget) begin
               cmd.set_stat  = 1'b1;
               cmd.stat_code = ST_DEADLINE;
               state_in      = S_FINISH;
            end else begin
               cmd.exec = 1'b1;
               state_in = S_FINISH;
               case (st.code_byte)
                  OP_NOP, OP_NOP_A, OP_NOP_B: state_in = S_FINISH;
                  OP_PUSH: begin
                     cmd.set_await  = 1'b1;
                     cmd.await_code = AW_PUSH;
                  end
                  OP_CID: begin
                     cmd.set_await  = 1'b1;
                     cmd.await_code = AW_CID;
                  end
                  OP_HALT: cmd.halt = 1'b1;
                  OP_POP: begin
                     path_in  = PT_DROP;
                     state_in = S_POPA;
                  end
                  OP_DUP, OP_NEG, OP_ABS: begin
                     if (st.empty) begin
                        cmd.set_stat  = 1'b1;
                        cmd.stat_code = ST_UNDER;
                     end else begin
                        path_in  = PT_ALU;
                        two_in   = st.code_byte == OP_DUP;
                        state_in = S_POPA;
                     end
                  end
                  OP_SWAP: begin
                     if (st.lt2) begin
                        cmd.set_stat  = 1'b1;
                        cmd.stat_code = ST_UNDER;
                     end else begin
                        path_in  = PT_ALU;
                        two_in   = 1'b1;
                        state_in = S_POPB;
                     end
                  end
                  OP_ADD, OP_SUB, OP_MUL, OP_LT, OP_GT, OP_LE, OP_GE: begin
                     path_in  = PT_ALU;
                     state_in = S_POPB;
                  end
                  OP_DIV: begin
                     path_in  = PT_DIV;
                     state_in = S_POPB;
                  end
                  OP_RANGE: begin
                     path_in  = PT_ALU;
                     state_in = S_POPC;
                  end
                  default: begin
                     cmd.set_stat  = 1'b1;
                     cmd.stat_code = ST_BADOP;
                  end
               endcase
            end
         end
         S_POPC, S_POPB, S_POPA: begin
            if (st.empty) begin
               cmd.set_stat  = 1'b1;
               cmd.stat_code = ST_UNDER;
               state_in      = S_FINISH;
            end else begin
               case (state_ff)
                  S_POPC: begin
                     cmd.pop_c = 1'b1;
                     state_in  = S_POPB;
                  end
                  S_POPB: begin
                     cmd.pop_b = 1'b1;
                     state_in  = S_POPA;
                  end
                  default: begin
                     cmd.pop_a = 1'b1;
                     case (path_ff)
                        PT_ALU:  state_in = S_ALU;
                        PT_DIV:  state_in = S_DIVCHK;
                        default: state_in = S_FINISH;
                     endcase
                  end
               endcase
            end
         end
         S_ALU: begin
            cmd.alu  = 1'b1;
            state_in = S_PUSH1;
         end
         S_DIVCHK: begin
            if (st.b_zero) begin
               cmd.set_stat  = 1'b1;
               cmd.stat_code = ST_DIVZ;
               state_in      = S_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIVW;
            end
         end
         S_DIVW: begin
            if (st.div_done) begin
               cmd.div_load = 1'b1;
               state_in     = S_PUSH1;
            end
         end
         S_PUSH1, S_PUSH2: begin
            if (st.full) begin
               cmd.set_stat  = 1'b1;
               cmd.stat_code = ST_OVER;
               state_in      = S_FINISH;
            end else begin
               cmd.push   = 1'b1;
               cmd.push_a = state_ff == S_PUSH2;
               state_in   = (state_ff == S_PUSH1 && two_ff) ? S_PUSH2 : S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_tready = ready_ff;

endmodule

// ===== rtl/core/saturating_stack_bytecode_checker_unit.sv =====
// channel  dir  handshake               payload
// req      in   req_tvalid, req_tready  tdata code_byte, sample; tlast last_byte;
//                                       tuser command
// rsp      out  rsp_tvalid, rsp_tready  tdata status .. stack_depth; tlast done_res;
//                                       tuser ignored
// csr      in   csr_we                  csr_wdata instruction_budget
//
// one beat in flight at a time; each stack pop or push is its own step
// through the stack memory, as is the alu step
// a divide waits on the 8-step shift-subtract divider
// a finished result sits in the output register while the next req beat is taken
// reset is synchronous; the stack memory is not cleared, depth tracking guards reads
module saturating_stack_bytecode_checker_unit #(
   parameter  int STACK_DEPTH = sbc_pkg::STACK_DEPTH_DEF,
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1),
   localparam int RSP_BITS    = 33 + DEPTH_W,
   localparam int RSP_DATA_W  = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // code_byte [7:0], sample [19:8], zero pad
   input  logic [sbc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   // command
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // status, violation_mask, severity, instruction_count, top_value, stack_depth, zero pad
   output logic [RSP_DATA_W-1:0]          rsp_tdata,
   output logic                           rsp_tlast,
   // ignored
   output logic                           rsp_tuser,
   input  logic                           csr_we,
   input  logic [sbc_pkg::BUDGET_W-1:0]   csr_wdata
);
   import sbc_pkg::*;

   dp_cmd_type            cmd;
   dp_status_type         st;
   logic                  out_free;
   logic                  rsp_load;
   logic                  done_res;
   status_type            status;
   logic                  ignored;
   logic [7:0]            violation_mask;
   logic [1:0]            severity;
   logic [BUDGET_W-1:0]   instruction_count;
   logic signed [7:0]     top_value;
   logic [DEPTH_W-1:0]    stack_depth;
   logic [RSP_DATA_W-1:0] rsp_pack;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;
   logic                  rsp_user_ff;

   sbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .out_free   (out_free),
      .st         (st),
      .cmd        (cmd),
      .req_tready (req_tready),
      .rsp_load   (rsp_load)
   );

   sbc_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .in_command        (req_tuser),
      .in_code_byte      (req_tdata[BYTE_W-1:0]),
      .in_last           (req_tlast),
      .in_sensor         (req_tdata[BYTE_W+SENSOR_W-1:BYTE_W]),
      .cmd               (cmd),
      .st                (st),
      .done_res          (done_res),
      .status            (status),
      .ignored           (ignored),
      .violation_mask    (violation_mask),
      .severity          (severity),
      .instruction_count (instruction_count),
      .top_value         (top_value),
      .stack_depth       (stack_depth)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_pack = RSP_DATA_W'({stack_depth, top_value, instruction_count,
                                  severity, violation_mask, status});

   always_comb begin
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_pack;
         rsp_last_ff <= done_res;
         rsp_user_ff <= ignored;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== rtl/core/sbc_check.sv =====
module sbc_check #(
   parameter  int STACK_DEPTH = sbc_pkg::STACK_DEPTH_DEF,
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1),
   localparam int RSP_DATA_W  = ((33 + DEPTH_W + 7) / 8) * 8
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast,
   input logic                  rsp_tuser
);
   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // one beat in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken while a beat is in flight");

   // a dropped byte never finishes or fails
   a_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tlast && rsp_tdata[2:0] == 3'd0)
      else $error("ignored beat with done or error");

   // an error always ends the check
   a_err_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != 3'd0 |-> rsp_tlast)
      else $error("error status without done");

   // severity only on a clean finish
   a_sev: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12:11] != 2'd0 |-> rsp_tlast && rsp_tdata[2:0] == 3'd0)
      else $error("severity outside a clean finish");

endmodule

bind saturating_stack_bytecode_checker_unit sbc_check #(
   .STACK_DEPTH (STACK_DEPTH)
) u_sbc_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
